### rtl/spectrum_phase_ramp_shift_top_assert.svh
// Assertion macros used by the phase ramp shift top level.
`ifndef SPECTRUM_PHASE_RAMP_SHIFT_TOP_ASSERT_SVH
`define SPECTRUM_PHASE_RAMP_SHIFT_TOP_ASSERT_SVH

// ante holds at an edge, cons must hold at the next edge
`define SPRS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// ante and cons at the same edge
`define SPRS_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

### rtl/sprs_pkg.sv
// Shared types, register codes and sine table generator for the phase ramp shift.
package sprs_pkg;

    localparam int FRAME_BINS_W = 17;
    localparam int PHASE_STEP_W = 32;
    localparam int CFG_DATA_W   = 32;
    localparam int CFG_INDEX_W  = 1;
    localparam logic [FRAME_BINS_W-1:0] FRAME_BINS_RESET = 17'd1024;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_FRAME_BINS = 1'b0,
        CFG_PHASE_STEP = 1'b1
    } t_cfg_reg;

    typedef enum logic [1:0] {
        QUAD_0   = 2'd0,
        QUAD_90  = 2'd1,
        QUAD_180 = 2'd2,
        QUAD_270 = 2'd3
    } t_quad;

    localparam logic [63:0] HALFPI_Q62 = 64'h6487ED5110B4611A;
    localparam logic [63:0] TAYLOR_DIV [12] = '{
        64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156,
        64'd210, 64'd272, 64'd342, 64'd420, 64'd506, 64'd600
    };

    function automatic logic [63:0] mul_q62(logic [63:0] a, logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return p[125:62];
    endfunction

    // sin(pi/2 * j / 2^tab_bits) in Q(smp_bits-1), Taylor series in Q62
    function automatic logic [63:0] sine_q(int j, int tab_bits, int smp_bits);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] sum;
        x    = (HALFPI_Q62 >> tab_bits) * 64'(j);
        x2   = mul_q62(x, x);
        term = x;
        sum  = x;
        for (int n = 1; n <= 12; n++) begin
            term = mul_q62(term, x2) / TAYLOR_DIV[n-1];
            if ((n % 2) == 1) begin
                sum = sum - term;
            end else begin
                sum = sum + term;
            end
        end
        return (sum + (64'd1 << (62 - smp_bits))) >> (63 - smp_bits);
    endfunction

endpackage

### rtl/sprs_sine_rom.sv
// Quarter-wave sine ROM with two registered read ports.
module sprs_sine_rom
    import sprs_pkg::*;
#(
    parameter int SAMPLE_BITS     = 16,
    parameter int TABLE_ADDR_BITS = 10
) (
    input  logic                       i_clk,
    input  logic                       i_rd_en,
    input  logic [TABLE_ADDR_BITS:0]   i_sin_addr,
    input  logic [TABLE_ADDR_BITS:0]   i_cos_addr,
    output logic [SAMPLE_BITS-1:0]     o_sin,
    output logic [SAMPLE_BITS-1:0]     o_cos
);

    localparam int TABLE_LEN = (1 << TABLE_ADDR_BITS) + 1;

    typedef logic [SAMPLE_BITS-1:0] t_rom [TABLE_LEN];

    function automatic t_rom build_rom();
        t_rom rom;
        for (int j = 0; j < TABLE_LEN; j++) begin
            rom[j] = SAMPLE_BITS'(sine_q(j, TABLE_ADDR_BITS, SAMPLE_BITS));
        end
        return rom;
    endfunction

    localparam t_rom SINE_ROM = build_rom();

    logic [SAMPLE_BITS-1:0] r_sin;
    logic [SAMPLE_BITS-1:0] r_cos;

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_sin <= SINE_ROM[i_sin_addr];
            r_cos <= SINE_ROM[i_cos_addr];
        end
    end

    assign o_sin = r_sin;
    assign o_cos = r_cos;

endmodule

### rtl/spectrum_phase_ramp_shift_top.sv
// Top level of the spectrum phase ramp shift: accumulator, rotation pipeline, config.
//
// Multiplies bin k of each frame by exp(-2*pi*i*k*step).
// Input channel: i_in_valid / o_in_stall with i_sample_re, i_sample_im.
// Output channel: o_out_valid / i_out_stall with o_result_re, o_result_im,
// o_frame_end (high on the last bin of a frame).
// Config: i_cfg_we writes i_cfg_data to register i_cfg_index (0: frame_bins,
// 1: phase_step); write only while no bins are in flight.
// Throughput: one bin per clock while the receiver does not stall. An input
// transfer passes the sine ROM read, product and round/saturate registers.
// The phase accumulator and bin counter update on every input transfer, so
// consecutive bins need no gap.
// Reset: frame_bins = 1024, phase_step = 0, position and phase zero, pipeline
// empty. No clearing pass; the sine ROM is constant.
// Receiver stall: the output register holds; each full stage holds while the stage
// after it holds, and o_in_stall rises once the first stage is held.
`include "spectrum_phase_ramp_shift_top_assert.svh"

module spectrum_phase_ramp_shift_top
    import sprs_pkg::*;
#(
    parameter int MAX_BINS        = 65536,
    parameter int SAMPLE_BITS     = 16,
    parameter int TABLE_ADDR_BITS = 10,
    parameter int PHASE_BITS      = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [CFG_INDEX_W-1:0]        i_cfg_index,
    input  logic [CFG_DATA_W-1:0]         i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic signed [SAMPLE_BITS-1:0] i_sample_re,
    input  logic signed [SAMPLE_BITS-1:0] i_sample_im,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic signed [SAMPLE_BITS-1:0] o_result_re,
    output logic signed [SAMPLE_BITS-1:0] o_result_im,
    output logic                          o_frame_end
);

    localparam int CNT_W = $clog2(MAX_BINS + 1);
    localparam int POS_W = (CNT_W < FRAME_BINS_W) ? CNT_W : FRAME_BINS_W;
    localparam int TAB   = TABLE_ADDR_BITS;
    localparam int XW    = SAMPLE_BITS + 1;
    localparam int PW    = 2 * SAMPLE_BITS + 2;
    localparam int SW    = PW + 1;
    localparam int RW    = SW - (SAMPLE_BITS - 1);

    localparam logic [20:0]  MAX_LEN = 21'(MAX_BINS);
    localparam logic [TAB:0] QUARTER = (TAB + 1)'(1) << TAB;
    localparam logic signed [SW-1:0] RND = SW'(1) << (SAMPLE_BITS - 2);
    localparam logic signed [RW-1:0] SAT_HI =
        {{(RW - SAMPLE_BITS + 1){1'b0}}, {(SAMPLE_BITS - 1){1'b1}}};
    localparam logic signed [RW-1:0] SAT_LO =
        {{(RW - SAMPLE_BITS + 1){1'b1}}, {(SAMPLE_BITS - 1){1'b0}}};

    // config registers
    logic [FRAME_BINS_W-1:0] r_frame_bins;
    logic [PHASE_STEP_W-1:0] r_phase_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_bins <= FRAME_BINS_RESET;
            r_phase_step <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_reg'(i_cfg_index))
                CFG_FRAME_BINS: r_frame_bins <= i_cfg_data[FRAME_BINS_W-1:0];
                CFG_PHASE_STEP: r_phase_step <= i_cfg_data[PHASE_STEP_W-1:0];
                default: ;
            endcase
        end
    end

    // pipeline control
    logic r1_valid, r2_valid, r3_valid;
    logic en1, en2, en3;
    logic in_xfer;

    assign en3        = !r3_valid || !i_out_stall;
    assign en2        = !r2_valid || en3;
    assign en1        = !r1_valid || en2;
    assign o_in_stall = !en1;
    assign in_xfer    = i_in_valid && en1;

    // accumulator and bin position
    logic [POS_W-1:0]      r_pos;
    logic [PHASE_BITS-1:0] r_phase;
    logic [POS_W-1:0]      len;
    logic [POS_W:0]        pos_inc;
    logic                  end_now;

    always_comb begin
        if (r_frame_bins == '0) begin
            len = POS_W'(1);
        end else if (21'(r_frame_bins) > MAX_LEN) begin
            len = POS_W'(MAX_LEN);
        end else begin
            len = POS_W'(r_frame_bins);
        end
        pos_inc = {1'b0, r_pos} + (POS_W + 1)'(1);
        end_now = pos_inc >= {1'b0, len};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_phase <= '0;
        end else if (in_xfer) begin
            if (end_now) begin
                r_pos   <= '0;
                r_phase <= '0;
            end else begin
                r_pos   <= pos_inc[POS_W-1:0];
                r_phase <= r_phase + PHASE_BITS'(r_phase_step);
            end
        end
    end

    // stage 1: quadrant rotation and table address
    logic [47:0]           p48;
    t_quad                 quad;
    logic [TAB+1:0]        idx_t;
    logic [TAB:0]          sin_addr;
    logic [TAB:0]          cos_addr;
    logic signed [XW-1:0]  xr_in, xi_in, xr_rot, xi_rot;

    always_comb begin
        p48      = 48'(r_phase) << (48 - PHASE_BITS);
        quad     = t_quad'(p48[47:46]);
        idx_t    = {1'b0, p48[45 -: TAB + 1]} + (TAB + 2)'(1);
        sin_addr = idx_t[TAB+1:1];
        cos_addr = QUARTER - sin_addr;
        xr_in    = XW'(i_sample_re);
        xi_in    = XW'(i_sample_im);
        case (quad)
            QUAD_0: begin
                xr_rot = xr_in;
                xi_rot = xi_in;
            end
            QUAD_90: begin
                xr_rot = xi_in;
                xi_rot = -xr_in;
            end
            QUAD_180: begin
                xr_rot = -xr_in;
                xi_rot = -xi_in;
            end
            QUAD_270: begin
                xr_rot = -xi_in;
                xi_rot = xr_in;
            end
            default: begin
                xr_rot = xr_in;
                xi_rot = xi_in;
            end
        endcase
    end

    logic signed [XW-1:0]   r1_xr, r1_xi;
    logic                   r1_end;
    logic [SAMPLE_BITS-1:0] rom_sin, rom_cos;

    sprs_sine_rom #(
        .SAMPLE_BITS     (SAMPLE_BITS),
        .TABLE_ADDR_BITS (TABLE_ADDR_BITS)
    ) u_rom (
        .i_clk      (i_clk),
        .i_rd_en    (en1),
        .i_sin_addr (sin_addr),
        .i_cos_addr (cos_addr),
        .o_sin      (rom_sin),
        .o_cos      (rom_cos)
    );

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r1_xr  <= xr_rot;
            r1_xi  <= xi_rot;
            r1_end <= end_now;
        end
    end

    // stage 2: products
    logic signed [XW-1:0] c_s, s_s;
    logic signed [PW-1:0] r2_prc, r2_pis, r2_pic, r2_prs;
    logic                 r2_end;

    assign c_s = $signed({1'b0, rom_cos});
    assign s_s = $signed({1'b0, rom_sin});

    always_ff @(posedge i_clk) begin
        if (en2) begin
            r2_prc <= r1_xr * c_s;
            r2_pis <= r1_xi * s_s;
            r2_pic <= r1_xi * c_s;
            r2_prs <= r1_xr * s_s;
            r2_end <= r1_end;
        end
    end

    // stage 3: sum, round half up, saturate
    logic signed [SW-1:0]          sum_re, sum_im;
    logic signed [RW-1:0]          rnd_re, rnd_im;
    logic signed [SAMPLE_BITS-1:0] sat_re, sat_im;
    logic signed [SAMPLE_BITS-1:0] r3_re, r3_im;
    logic                          r3_end;

    always_comb begin
        sum_re = SW'(r2_prc) + SW'(r2_pis) + RND;
        sum_im = SW'(r2_pic) - SW'(r2_prs) + RND;
        rnd_re = RW'(sum_re >>> (SAMPLE_BITS - 1));
        rnd_im = RW'(sum_im >>> (SAMPLE_BITS - 1));
        if (rnd_re > SAT_HI) begin
            sat_re = SAT_HI[SAMPLE_BITS-1:0];
        end else if (rnd_re < SAT_LO) begin
            sat_re = SAT_LO[SAMPLE_BITS-1:0];
        end else begin
            sat_re = rnd_re[SAMPLE_BITS-1:0];
        end
        if (rnd_im > SAT_HI) begin
            sat_im = SAT_HI[SAMPLE_BITS-1:0];
        end else if (rnd_im < SAT_LO) begin
            sat_im = SAT_LO[SAMPLE_BITS-1:0];
        end else begin
            sat_im = rnd_im[SAMPLE_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en3) begin
            r3_re  <= sat_re;
            r3_im  <= sat_im;
            r3_end <= r2_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
        end else begin
            if (en1) begin
                r1_valid <= i_in_valid;
            end
            if (en2) begin
                r2_valid <= r1_valid;
            end
            if (en3) begin
                r3_valid <= r2_valid;
            end
        end
    end

    assign o_out_valid = r3_valid;
    assign o_result_re = r3_re;
    assign o_result_im = r3_im;
    assign o_frame_end = r3_end;

    `SPRS_ASSERT_NEXT(a_frame_restart, in_xfer && end_now,
        r_pos == '0 && r_phase == '0, "phase or position not cleared at frame end")
    `SPRS_ASSERT_NEXT(a_phase_advance, in_xfer && !end_now,
        r_phase == PHASE_BITS'($past(r_phase) + PHASE_BITS'($past(r_phase_step))),
        "phase did not advance by step")
    `SPRS_ASSERT_NEXT(a_stage2_hold, r2_valid && !en3,
        r2_valid && $stable(r2_prc) && $stable(r2_pic), "held product stage changed")
    `SPRS_ASSERT_SAME(a_stall_full, o_in_stall,
        r1_valid && r2_valid && r3_valid, "input stalled with a free stage")

endmodule

### tb/spectrum_phase_ramp_shift_top_test.sv
// Self-checking testbench for the spectrum phase ramp shift block.
module spectrum_phase_ramp_shift_top_test
    import sprs_pkg::*;
;

    localparam int CYCLE_LIMIT = 400000;
    localparam int RAND_SEGMENTS = 15;
    localparam int SEGMENT_BINS = 30;

    localparam logic [15:0] CORNER_RE [8] = '{
        16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h0000, 16'h0001, 16'hFFFF, 16'h5A5A
    };
    localparam logic [15:0] CORNER_IM [8] = '{
        16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF, 16'h0001, 16'hEDCC
    };

    typedef struct {
        logic [15:0] re;
        logic [15:0] im;
        logic        frame_end;
    } t_bin;

    class phase_ramp_scoreboard;
        int          sine_lut [0:1024];
        int          frame_len;
        logic [31:0] step;
        int          position;
        logic [31:0] acc;
        t_bin        pending [$];
        int          errors;

        function new();
            frame_len = int'(FRAME_BINS_RESET);
            step      = '0;
            position  = 0;
            acc       = '0;
            errors    = 0;
            build_sine();
        endfunction

        function logic [63:0] q62_product(logic [63:0] a, logic [63:0] b);
            logic [127:0] full;
            full = {64'd0, a} * {64'd0, b};
            return full[125:62];
        endfunction

        function void build_sine();
            logic [63:0] ang;
            logic [63:0] sq;
            logic [63:0] term;
            logic [63:0] series;
            for (int j = 0; j <= 1024; j++) begin
                ang    = (64'h6487ED5110B4611A >> 10) * 64'(j);
                sq     = q62_product(ang, ang);
                term   = ang;
                series = ang;
                for (int n = 1; n <= 12; n++) begin
                    term = q62_product(term, sq) / 64'((2 * n) * (2 * n + 1));
                    if (n % 2 == 1) begin
                        series = series - term;
                    end else begin
                        series = series + term;
                    end
                end
                sine_lut[j] = int'((series + (64'd1 << 46)) >> 47);
            end
        endfunction

        function void configure(t_cfg_reg idx, logic [31:0] data);
            if (idx == CFG_FRAME_BINS) begin
                frame_len = int'(data[16:0]);
            end else begin
                step = data;
            end
        endfunction

        function logic [15:0] rounded(longint v);
            longint r;
            r = (v + 64'sd16384) >>> 15;
            if (r > 32767) r = 32767;
            if (r < -32768) r = -32768;
            return r[15:0];
        endfunction

        function void note_input(logic signed [15:0] re, logic signed [15:0] im);
            t_quad  q;
            int     idx;
            int     len;
            longint xr;
            longint xi;
            longint t;
            longint c;
            longint s;
            t_bin   want;
            q   = t_quad'(acc[31:30]);
            idx = (int'(acc[29:19]) + 1) >> 1;
            xr  = re;
            xi  = im;
            case (q)
                QUAD_90: begin
                    t = xr; xr = xi; xi = -t;
                end
                QUAD_180: begin
                    xr = -xr; xi = -xi;
                end
                QUAD_270: begin
                    t = xr; xr = -xi; xi = t;
                end
                default: ;
            endcase
            c = sine_lut[1024 - idx];
            s = sine_lut[idx];
            want.re = rounded(xr * c + xi * s);
            want.im = rounded(xi * c - xr * s);
            len = (frame_len == 0) ? 1 : ((frame_len > 65536) ? 65536 : frame_len);
            position++;
            if (position >= len) begin
                want.frame_end = 1'b1;
                position = 0;
                acc = '0;
            end else begin
                want.frame_end = 1'b0;
                acc = acc + step;
            end
            pending.push_back(want);
        endfunction

        function void check_result(logic [15:0] re, logic [15:0] im, logic fe);
            t_bin want;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result re %0d im %0d frame_end %0b",
                         $time, $signed(re), $signed(im), fe);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (re !== want.re) begin
                $display("%0t: result_re expected %0d actual %0d",
                         $time, $signed(want.re), $signed(re));
                errors++;
            end
            if (im !== want.im) begin
                $display("%0t: result_im expected %0d actual %0d",
                         $time, $signed(want.im), $signed(im));
                errors++;
            end
            if (fe !== want.frame_end) begin
                $display("%0t: frame_end expected %0b actual %0b", $time, want.frame_end, fe);
                errors++;
            end
        endfunction
    endclass

    logic                   i_clk;
    logic                   i_rst_n = 1'b0;
    logic                   i_cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0] i_cfg_index = CFG_FRAME_BINS;
    logic [CFG_DATA_W-1:0]  i_cfg_data = '0;
    logic                   i_in_valid = 1'b0;
    logic                   o_in_stall;
    logic signed [15:0]     i_sample_re = '0;
    logic signed [15:0]     i_sample_im = '0;
    logic                   o_out_valid;
    logic                   i_out_stall = 1'b0;
    logic signed [15:0]     o_result_re;
    logic signed [15:0]     o_result_im;
    logic                   o_frame_end;

    int tx_idle_pct = 26;
    int rx_idle_pct = 70;
    int cycles = 0;

    phase_ramp_scoreboard sb = new();

    spectrum_phase_ramp_shift_top u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_sample_re (i_sample_re),
        .i_sample_im (i_sample_im),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_result_re (o_result_re),
        .o_result_im (o_result_im),
        .o_frame_end (o_frame_end)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("spectrum_phase_ramp_shift_top_test failed");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            sb.check_result(o_result_re, o_result_im, o_frame_end);
        end
        i_out_stall <= ($urandom_range(99) < rx_idle_pct);
    end

    task automatic send_bin(input logic [15:0] re, input logic [15:0] im);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_sample_re <= re;
        i_sample_im <= im;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sb.note_input(re, im);
    endtask

    task automatic close_segment();
        i_in_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
    endtask

    task automatic program_regs(input logic [31:0] frame_word, input logic [31:0] step_word);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_FRAME_BINS;
        i_cfg_data  <= frame_word;
        @(posedge i_clk);
        sb.configure(CFG_FRAME_BINS, frame_word);
        i_cfg_index <= CFG_PHASE_STEP;
        i_cfg_data  <= step_word;
        @(posedge i_clk);
        sb.configure(CFG_PHASE_STEP, step_word);
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [15:0] pick_sample();
        case ($urandom_range(0, 9))
            0: return 16'h8000;
            1: return 16'h7FFF;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [16:0] pick_frame_bins();
        case ($urandom_range(0, 13))
            0: return 17'd0;
            1: return 17'd1;
            2: return 17'd2;
            3: return 17'd3;
            4: return 17'd5;
            5: return 17'd8;
            6: return 17'd17;
            7: return 17'd1024;
            8: return 17'd65535;
            9: return 17'd65536;
            10: return 17'h1FFFF;
            default: return 17'($urandom_range(1, 40));
        endcase
    endfunction

    function automatic logic [31:0] pick_step(input int len);
        case ($urandom_range(0, 9))
            0: return 32'h0000_0000;
            1: return 32'h4000_0000;
            2: return 32'h8000_0000;
            3: return 32'hC000_0000;
            4: return 32'hFFFF_FFFF;
            5: return 32'((64'($urandom_range(0, len - 1)) << 32) / 64'(len));
            6: return 32'((64'(len / 2) << 32) / 64'(len));
            7: return -32'((64'(len / 2) << 32) / 64'(len));
            default: return $urandom;
        endcase
    endfunction

    initial begin
        logic [16:0] fb;
        int          len;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: zero step passes bins through
        for (int i = 0; i < 4; i++) send_bin(CORNER_RE[i], CORNER_IM[i]);
        close_segment();
        // quarter-turn step walks through all four exact rotations
        program_regs(32'd4, 32'h4000_0000);
        for (int i = 0; i < 8; i++) send_bin(CORNER_RE[i], CORNER_IM[i]);
        close_segment();
        // zero length acts as one
        program_regs(32'd0, 32'h9E37_79B9);
        for (int i = 0; i < 4; i++) send_bin(CORNER_RE[i + 4], CORNER_IM[i + 4]);
        close_segment();
        program_regs(32'd3, 32'h0000_0000);
        for (int i = 0; i < 4; i++) send_bin(CORNER_RE[i], CORNER_IM[i]);
        close_segment();
        // oversize length saturates, upper data bits dropped
        program_regs(32'hFFFF_FFFF, 32'h8000_0000);
        for (int i = 0; i < 4; i++) send_bin(CORNER_RE[i + 2], CORNER_IM[i + 2]);
        close_segment();

        for (int seg = 0; seg < RAND_SEGMENTS; seg++) begin
            case (seg / 5)
                0: begin
                    tx_idle_pct = 26; rx_idle_pct = 70;
                end
                1: begin
                    tx_idle_pct = 70; rx_idle_pct = 26;
                end
                default: begin
                    tx_idle_pct = 0; rx_idle_pct = 0;
                end
            endcase
            fb  = pick_frame_bins();
            len = (fb == 0) ? 1 : ((fb > 17'd65536) ? 65536 : int'(fb));
            program_regs({15'($urandom), fb}, pick_step(len));
            for (int i = 0; i < SEGMENT_BINS; i++) send_bin(pick_sample(), pick_sample());
            close_segment();
        end

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("spectrum_phase_ramp_shift_top_test passed");
        end else begin
            $display("spectrum_phase_ramp_shift_top_test failed");
        end
        $finish;
    end

endmodule

### spectrum_phase_ramp_shift_top.f
+incdir+rtl
rtl/sprs_pkg.sv
rtl/sprs_sine_rom.sv
rtl/spectrum_phase_ramp_shift_top.sv
tb/spectrum_phase_ramp_shift_top_test.sv
